[src/sgls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Semantic grid label store package
// Shared sizes, operation codes and register indexes.
// ----------------------------------------------------------------------------
package sgls_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_READ   = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_COUNT  = 3'd3,
    OP_BOUNDS = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_CELL     = 3'd2,
    REG_COLS     = 3'd3,
    REG_ROWS     = 3'd4
  } reg_idx_t;

  localparam logic [3:0] LABEL_UNKNOWN = 4'hF;
  localparam logic [7:0] CERT_UNKNOWN = 8'hFF;
  localparam logic [7:0] CERT_MAX = 8'd100;

endpackage : sgls_pkg
`default_nettype wire

[src/sgls_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Semantic grid label store divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module sgls_divider (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [33:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic signed [33:0] quotient
);
  import sgls_pkg::*;

  logic [33:0] mag_r, mag_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] shifted;

  always_comb begin
    mag_nxt = mag_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r[15:0], mag_r[33]};
    trial = shifted - {1'b0, dvs_r};
    if (start) begin
      neg_nxt = dividend[33];
      mag_nxt = dividend[33] ? (34'd0 - dividend) : dividend;
      rem_nxt = '0;
      dvs_nxt = (divisor == 16'd0) ? 16'd1 : divisor;
      cnt_nxt = 6'd34;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = trial;
        mag_nxt = {mag_r[32:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        mag_nxt = {mag_r[32:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quotient = neg_r ? (34'sd0 - $signed(mag_r)) : $signed(mag_r);

endmodule : sgls_divider
`default_nettype wire

[src/semantic_grid_label_store_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Semantic grid label store unit
// Grid of room labels and certainty codes with set, read, clear, count and
// known-region bounds requests.
// ----------------------------------------------------------------------------
// Set and read run two serial 34-step divisions in one shared divider, then a
// memory read and, for set, a write; outside the grid no memory access is made.
// Clear, count and bounds walk all 65536 cells, one per cycle; bounds then
// computes the cell centres when a known cell exists. Unused codes give a miss.
// After reset a clearing pass over all 65536 cells runs with busy high.
// One request at a time; each result strobes out for one cycle and cannot stall.
module semantic_grid_label_store_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [31:0] in_coord_x_mm,
  input  wire logic signed [31:0] in_coord_y_mm,
  input  wire logic signed [7:0]  in_label_in,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic signed [4:0]       out_label_out,
  output logic signed [7:0]       out_certainty,
  output logic                    out_was_clamped,
  output logic [16:0]             out_cell_total,
  output logic signed [31:0]      out_low_x_mm,
  output logic signed [31:0]      out_low_y_mm,
  output logic signed [31:0]      out_high_x_mm,
  output logic signed [31:0]      out_high_y_mm,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import sgls_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DIVX, ST_DIVY, ST_RD, ST_RDW, ST_WR,
    ST_SWEEP, ST_DRAIN, ST_FIN, ST_CX, ST_OUT
  } state_t;

  state_t state_r;
  logic signed [31:0] cfg_origin_x_r, cfg_origin_y_r;
  logic [15:0] cfg_cell_size_r;
  logic [8:0]  cfg_grid_cols_r, cfg_grid_rows_r;

  logic [3:0] lab_mem [2**ADDR_W];
  logic [7:0] cert_mem [2**ADDR_W];
  logic [3:0] lab_q;
  logic [7:0] cert_q;
  logic signed [4:0] lab_q_ext;
  logic       mem_we;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [3:0] mem_wl;
  logic [7:0] mem_wc;

  logic [2:0] op_r;
  logic signed [31:0] y_r;
  logic signed [7:0] lab_in_r;
  logic [ADDR_W:0] sweep_r;
  logic [ADDR_W-1:0] pipe_idx_r;
  logic pipe_v_r;
  logic signed [33:0] col_r;
  logic [16:0] total_r;
  logic found_r;
  logic [COL_W-1:0] minc_r, maxc_r;
  logic [ROW_W-1:0] minr_r, maxr_r;
  logic [1:0] cx_r;
  logic signed [31:0] cx_res_r [4];

  logic div_start, div_done;
  logic [33:0] div_dividend;
  logic signed [33:0] div_q;

  logic [9:0] used_cols, used_rows;
  logic in_grid;
  logic signed [4:0] clamp_lab;
  logic clamp_flag;
  logic [7:0] new_cert;
  logic cfg_wr;

  sgls_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(cfg_cell_size_r), .done(div_done), .quotient(div_q)
  );

  assign used_cols = (cfg_grid_cols_r > 9'(MAX_COLS)) ? 10'(MAX_COLS) : {1'b0, cfg_grid_cols_r};
  assign used_rows = (cfg_grid_rows_r > 9'(MAX_ROWS)) ? 10'(MAX_ROWS) : {1'b0, cfg_grid_rows_r};

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[4:2])
      REG_ORIGIN_X: prdata = cfg_origin_x_r;
      REG_ORIGIN_Y: prdata = cfg_origin_y_r;
      REG_CELL:     prdata = {16'd0, cfg_cell_size_r};
      REG_COLS:     prdata = {23'd0, cfg_grid_cols_r};
      REG_ROWS:     prdata = {23'd0, cfg_grid_rows_r};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_origin_x_r <= '0;
      cfg_origin_y_r <= '0;
      cfg_cell_size_r <= 16'd50;
      cfg_grid_cols_r <= 9'd256;
      cfg_grid_rows_r <= 9'd256;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ORIGIN_X: cfg_origin_x_r <= pwdata;
        REG_ORIGIN_Y: cfg_origin_y_r <= pwdata;
        REG_CELL:     cfg_cell_size_r <= pwdata[15:0];
        REG_COLS:     cfg_grid_cols_r <= pwdata[8:0];
        REG_ROWS:     cfg_grid_rows_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lab_mem[mem_wa] <= mem_wl;
      cert_mem[mem_wa] <= mem_wc;
    end
    lab_q <= lab_mem[mem_ra];
    cert_q <= cert_mem[mem_ra];
  end

  // Stored labels 0 to 9 are unsigned; the all-ones code is unknown.
  assign lab_q_ext = (lab_q == LABEL_UNKNOWN) ? -5'sd1 : {1'b0, lab_q};

  // Shared divider input: x offset first, then y offset.
  assign div_dividend = (state_r == ST_IDLE)
      ? 34'(in_coord_x_mm) - 34'(cfg_origin_x_r)
      : 34'(y_r) - 34'(cfg_origin_y_r);
  assign div_start = (state_r == ST_IDLE && start &&
                      (in_op == OP_SET || in_op == OP_READ)) ||
                     (state_r == ST_DIVX && div_done);

  assign in_grid = !col_r[33] && !div_q[33] &&
                   (col_r < 34'(used_cols)) && (div_q < 34'(used_rows));

  always_comb begin
    clamp_flag = (lab_in_r < -8'sd1) || (lab_in_r > 8'sd9);
    if (lab_in_r < -8'sd1) clamp_lab = -5'sd1;
    else if (lab_in_r > 8'sd9) clamp_lab = 5'sd9;
    else clamp_lab = lab_in_r[4:0];
    if (cert_q == CERT_UNKNOWN || (lab_q == LABEL_UNKNOWN && clamp_lab != -5'sd1))
      new_cert = 8'd1;
    else if (lab_q_ext == clamp_lab)
      new_cert = (cert_q >= CERT_MAX) ? CERT_MAX : cert_q + 8'd1;
    else
      new_cert = (cert_q == 8'd0) ? 8'd0 : cert_q - 8'd1;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pipe_idx_r;
    mem_wl = clamp_lab[3:0];
    mem_wc = new_cert;
    mem_ra = sweep_r[ADDR_W-1:0];
    if (state_r == ST_INIT || (state_r == ST_SWEEP && op_r == OP_CLEAR)) begin
      mem_we = 1'b1;
      mem_wa = sweep_r[ADDR_W-1:0];
      mem_wl = LABEL_UNKNOWN;
      mem_wc = CERT_UNKNOWN;
    end else if (state_r == ST_WR && op_r == OP_SET) begin
      mem_we = 1'b1;
    end
    if (state_r == ST_DIVY) mem_ra = {div_q[ROW_W-1:0], col_r[COL_W-1:0]};
    if (state_r == ST_RD) mem_ra = pipe_idx_r;
  end

  function automatic logic signed [31:0] centre(input logic signed [31:0] org,
                                               input logic [COL_W-1:0] g,
                                               input logic [15:0] cs);
    logic signed [49:0] v;
    v = 50'(org) + 50'($signed({1'b0, 26'(g) * 26'(cs)})) + 50'(cs >> 1);
    if (v > 50'sd2147483647) centre = 32'h7FFFFFFF;
    else if (v < -50'sd2147483648) centre = 32'h80000000;
    else centre = v[31:0];
  endfunction

  logic [COL_W-1:0] pc;
  logic [ROW_W-1:0] pr;
  assign pc = pipe_idx_r[COL_W-1:0];
  assign pr = pipe_idx_r[ADDR_W-1:COL_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      sweep_r <= '0;
      out_valid <= 1'b0;
      pipe_v_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        ST_INIT: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == (ADDR_W+1)'(2**ADDR_W - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (start) begin
            op_r <= in_op;
            y_r <= in_coord_y_mm;
            lab_in_r <= in_label_in;
            sweep_r <= '0;
            total_r <= '0;
            found_r <= 1'b0;
            pipe_v_r <= 1'b0;
            out_hit <= 1'b0;
            out_label_out <= -5'sd1;
            out_certainty <= -8'sd1;
            out_was_clamped <= 1'b0;
            out_cell_total <= '0;
            out_low_x_mm <= '0;
            out_low_y_mm <= '0;
            out_high_x_mm <= '0;
            out_high_y_mm <= '0;
            unique case (in_op)
              OP_SET, OP_READ: state_r <= ST_DIVX;
              OP_CLEAR, OP_COUNT, OP_BOUNDS: state_r <= ST_SWEEP;
              default: state_r <= ST_OUT;
            endcase
          end
        end
        ST_DIVX: if (div_done) begin
          col_r <= div_q;
          state_r <= ST_DIVY;
        end
        ST_DIVY: if (div_done) begin
          pipe_idx_r <= {div_q[ROW_W-1:0], col_r[COL_W-1:0]};
          state_r <= in_grid ? ST_RD : ST_OUT;
        end
        ST_RD: state_r <= ST_WR;
        ST_WR: begin
          out_hit <= 1'b1;
          if (op_r == OP_SET) begin
            out_label_out <= clamp_lab;
            out_certainty <= new_cert;
            out_was_clamped <= clamp_flag;
          end else begin
            out_label_out <= lab_q_ext;
            out_certainty <= cert_q;
          end
          state_r <= ST_OUT;
        end
        ST_SWEEP, ST_DRAIN: begin
          sweep_r <= sweep_r + 1'b1;
          pipe_idx_r <= sweep_r[ADDR_W-1:0];
          pipe_v_r <= (state_r == ST_SWEEP);
          if (pipe_v_r && 10'(pc) < used_cols && 10'(pr) < used_rows) begin
            if (op_r == OP_COUNT && {{3{lab_q_ext[4]}}, lab_q_ext} == lab_in_r)
              total_r <= total_r + 17'd1;
            if (op_r == OP_BOUNDS && lab_q != LABEL_UNKNOWN) begin
              found_r <= 1'b1;
              if (!found_r) begin
                minc_r <= pc; maxc_r <= pc; minr_r <= pr; maxr_r <= pr;
              end else begin
                if (pc < minc_r) minc_r <= pc;
                if (pc > maxc_r) maxc_r <= pc;
                if (pr > maxr_r) maxr_r <= pr;
              end
            end
          end
          if (state_r == ST_SWEEP && sweep_r == (ADDR_W+1)'(2**ADDR_W - 1))
            state_r <= ST_DRAIN;
          else if (state_r == ST_DRAIN)
            state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (op_r == OP_COUNT) out_cell_total <= total_r;
          cx_r <= '0;
          state_r <= (op_r == OP_BOUNDS && found_r) ? ST_CX : ST_OUT;
        end
        ST_CX: begin
          unique case (cx_r)
            2'd0: cx_res_r[0] <= centre(cfg_origin_x_r, minc_r, cfg_cell_size_r);
            2'd1: cx_res_r[1] <= centre(cfg_origin_y_r, COL_W'(minr_r), cfg_cell_size_r);
            2'd2: cx_res_r[2] <= centre(cfg_origin_x_r, maxc_r, cfg_cell_size_r);
            default: cx_res_r[3] <= centre(cfg_origin_y_r, COL_W'(maxr_r), cfg_cell_size_r);
          endcase
          cx_r <= cx_r + 2'd1;
          if (cx_r == 2'd3) state_r <= ST_RDW;
        end
        ST_RDW: begin
          out_hit <= 1'b1;
          out_low_x_mm <= cx_res_r[0];
          out_low_y_mm <= cx_res_r[1];
          out_high_x_mm <= cx_res_r[2];
          out_high_y_mm <= cx_res_r[3];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held two cycles");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted without going busy");
  a_set_hit_label: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_label_out == -5'sd1 && !out_was_clamped))
    else $error("miss carries a label");

endmodule : semantic_grid_label_store_unit
`default_nettype wire
